@@ sv/cksh_pkg.sv @@
package cksh_pkg;

    // Reflected CRC-16 settings
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

    // Slot width kept from the inverted CRC (1 to 16) and the port width of a slot
    localparam int unsigned SLOT_BITS = 14;
    localparam int unsigned SLOT_W    = 14;

    // Width of the packed output tdata, filled up to whole bytes
    localparam int unsigned OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    // Mask on the 16-bit CRC that keeps the slot bits
    localparam logic [15:0] SLOT_MASK =
        (SLOT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SLOT_BITS) - 32'd1);

    // Fold one key byte into the running CRC: eight reflected bit-steps
    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc,
                                                  input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/crc16_key_slot_hash.sv @@
// o_m_axis_tvalid rises when a key's last item passes from the input to the result register.
// One item per cycle, unless a key's last item must wait for a held result; the CRC fold is
// eight combinational bit-steps between the input and running-CRC/result registers.
// Reset (i_rst_n low, synchronous): running CRC cleared to zero, both stages emptied.
// An empty key (tuser low with tlast high and no earlier bytes) gives slot 16383.
module crc16_key_slot_hash
    import cksh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input item stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [7:0] key_byte
    input  logic                   i_s_axis_tuser,   // [0] byte_valid
    input  logic                   i_s_axis_tlast,   // last_of_key
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // [13:0] slot_number, rest zero
);

    // Input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_bvalid;
    logic        r_s1_last;

    // Running CRC and result register
    logic [15:0]       r_crc;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;

    logic              out_free;
    logic              s1_go;
    logic [15:0]       n_crc;
    logic [15:0]       masked;
    logic [SLOT_W-1:0] n_slot;

    // Advance the input stage when its item needs no result or the result slot frees
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_go           = r_s1_valid && (!r_s1_last || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_go;

    // Fold the held byte and form the slot
    always_comb begin
        n_crc = r_s1_bvalid ? crc_fold_byte(r_crc, r_s1_byte) : r_crc;
        masked = (n_crc ^ CRC_XOROUT) & SLOT_MASK;
        n_slot = masked[SLOT_W-1:0];
    end

    // Capture an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_s1_byte   <= i_s_axis_tdata;
            r_s1_bvalid <= i_s_axis_tuser;
            r_s1_last   <= i_s_axis_tlast;
        end
    end

    // Update the running CRC; clear it at the end of a key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else if (s1_go) begin
            r_crc <= r_s1_last ? 16'h0000 : n_crc;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_go && r_s1_last) begin
            r_out_slot <= n_slot;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W){1'b0}}, r_out_slot};

endmodule

@@ bench/crc16_key_slot_hash_tb.sv @@
module crc16_key_slot_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cksh_pkg::*;

    // Track the running key CRC and hold the slots still owed by the block
    class key_slot_board;
        logic [15:0]       fold_lut [256];
        logic [15:0]       crc_acc;
        logic [SLOT_W-1:0] slot_q [$];
        int unsigned       bad_count;

        function new();
            logic [15:0] c;
            for (int i = 0; i < 256; i++) begin
                c = 16'(i);
                for (int k = 0; k < 8; k++) begin
                    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
                end
                fold_lut[i] = c;
            end
            crc_acc   = '0;
            bad_count = 0;
        endfunction

        // Fold the byte if present, then owe a slot when the key ends
        function void note_key_item(logic [7:0] key_byte, logic byte_ok, logic key_end);
            if (byte_ok) begin
                crc_acc = (crc_acc >> 8) ^ fold_lut[crc_acc[7:0] ^ key_byte];
            end
            if (key_end) begin
                slot_q.push_back(SLOT_W'((crc_acc ^ CRC_XOROUT) & SLOT_MASK));
                crc_acc = '0;
            end
        endfunction

        // Compare one result with the oldest slot owed; padding must be zero
        function void check_slot(logic [OUT_TDATA_W-1:0] got);
            logic [OUT_TDATA_W-1:0] want;
            if (slot_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("unexpected slot item: tdata=%h", got);
                end
                return;
            end
            want = OUT_TDATA_W'(slot_q.pop_front());
            if (got !== want) begin
                bad_count++;
                if (bad_count <= 10) begin
                    $display("slot mismatch: expected tdata=%h (slot %0d), got tdata=%h",
                             want, want, got);
                end
            end
        endfunction

        // Count any slot never delivered as a failure
        function void close_out();
            if (slot_q.size() != 0) begin
                $display("%0d slot items never arrived", slot_q.size());
                bad_count += slot_q.size();
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [7:0]             s_data  = '0;   // [7:0] key_byte
    logic                   s_user  = 1'b0; // [0] byte_valid
    logic                   s_last  = 1'b0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata; // [13:0] slot_number, rest zero

    int unsigned   idle_pct  = 32;
    int unsigned   fed_items = 0;
    key_slot_board board     = new();

    crc16_key_slot_hash dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random and check every accepted slot
    always @(posedge i_clk) begin
        if (o_m_axis_tvalid === 1'b1 && m_ready) begin
            board.check_slot(o_m_axis_tdata);
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // Offer one item after a random gap and hold it until it is taken
    task automatic send_key_item(input logic [7:0] b, input logic v, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= v;
        s_last  <= l;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_key_item(b, v, l);
        fed_items++;
    endtask

    // Send a whole key of random bytes, with stray idle steps inside;
    // end it either on the last byte or on a separate byteless marker
    task automatic send_random_key(input int unsigned len);
        bit split_end;
        split_end = ($urandom_range(3) == 0);
        if (len == 0) begin
            send_key_item(8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(7) == 0) begin
                send_key_item(8'($urandom), 1'b0, 1'b0);
            end
            send_key_item(8'($urandom), 1'b1, (i == len - 1) && !split_end);
        end
        if (split_end) begin
            send_key_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    initial begin
        logic [7:0]  check_str [9];
        int unsigned rand_start;
        int unsigned len;

        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
                      8'h36, 8'h37, 8'h38, 8'h39};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty key straight after reset, then an idle step
        send_key_item(8'h00, 1'b0, 1'b1);
        send_key_item(8'hA5, 1'b0, 1'b0);
        // Single-byte keys at both byte extremes
        send_key_item(8'h00, 1'b1, 1'b1);
        send_key_item(8'hFF, 1'b1, 1'b1);
        // Standard check string, ended on its last byte
        foreach (check_str[i]) begin
            send_key_item(check_str[i], 1'b1, i == 8);
        end
        // Bytes with an idle step between, closed by a byteless end
        send_key_item(8'hFF, 1'b1, 1'b0);
        send_key_item(8'h5A, 1'b0, 1'b0);
        send_key_item(8'h00, 1'b1, 1'b0);
        send_key_item(8'hFF, 1'b0, 1'b1);
        // Walking high and low bits
        send_key_item(8'h80, 1'b1, 1'b0);
        send_key_item(8'h01, 1'b1, 1'b0);
        send_key_item(8'h7F, 1'b1, 1'b1);

        // Mostly whole keys, some noise; a long stretch with no idle gaps in the middle
        rand_start = fed_items;
        while (fed_items < rand_start + 380) begin
            if (fed_items >= rand_start + 120 && fed_items < rand_start + 220) begin
                idle_pct = 0;
            end else begin
                idle_pct = 32;
            end
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(32, 17) : $urandom_range(8);
                send_random_key(len);
            end else begin
                send_key_item(8'($urandom), 1'($urandom), 1'($urandom));
            end
        end
        s_valid  <= 1'b0;
        idle_pct = 32;

        // Drain, then wait for any stray result
        while (board.slot_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        board.close_out();
        if (board.bad_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Give up if the run stalls
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
